/* hdl/bcc_pkg.sv */
package bcc_pkg;

  // default button count
  localparam int NUM_BUTTONS_DEF = 4;

  // field widths
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W   = 3;
  localparam int BTN_W    = 2;
  localparam int MODE_W   = 2;
  localparam int TIME_W   = 16;

  // at most this many timeout events per tick
  localparam int MAX_EVENTS = 4;
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_CLICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DBL_WINDOW = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] LONG_CLICK_RST = 16'd1000;
  localparam logic [CFG_W-1:0] MIN_PRESS_RST  = 16'd50;
  localparam logic [CFG_W-1:0] DBL_WINDOW_RST = 16'd300;

  // per-button mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PRESSED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WAIT    = 2'd2;

  // event kinds
  localparam logic [KIND_W-1:0] EV_PRESS   = 3'd0;
  localparam logic [KIND_W-1:0] EV_RELEASE = 3'd1;
  localparam logic [KIND_W-1:0] EV_CLICK   = 3'd2;
  localparam logic [KIND_W-1:0] EV_DOUBLE  = 3'd3;
  localparam logic [KIND_W-1:0] EV_LONG    = 3'd4;

  // request kinds
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic btn_step;
    logic scan_step;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_op;
    logic scan_last;
    logic out_free;
    logic pend_valid;
  } stat_t;

endpackage

/* hdl/bcc_ctrl.sv */
module bcc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output bcc_pkg::cmd_t cmd,
  input  bcc_pkg::stat_t stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BTN   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = (stat.req_op == bcc_pkg::OP_TICK) ? S_SCAN : S_BTN;
        end
      end
      S_BTN: begin
        if (stat.out_free) begin
          cmd.btn_step = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_SCAN: begin
        if (stat.out_free) begin
          cmd.scan_step = 1'b1;
          if (stat.scan_last) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/bcc_datapath.sv */
module bcc_datapath #(
  parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]       cfg_data,
  input  logic [7:0]                      s_tdata,
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,
  output logic [bcc_pkg::KIND_W-1:0]      m_tuser,
  output logic                            m_tlast,
  input  bcc_pkg::cmd_t                   cmd,
  output bcc_pkg::stat_t                  stat
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  // configuration registers
  logic [bcc_pkg::CFG_W-1:0] long_click_ms;
  logic [bcc_pkg::CFG_W-1:0] min_press_ms;
  logic [bcc_pkg::CFG_W-1:0] dblclick_window_ms;

  // per-button state
  logic [bcc_pkg::MODE_W-1:0] button_mode [NUM_BUTTONS];
  logic [bcc_pkg::TIME_W-1:0] elapsed_ms  [NUM_BUTTONS];

  // latched request
  logic [bcc_pkg::BTN_W-1:0] req_index;
  logic                      req_level;

  // scan control
  logic [IDX_W-1:0]          scan_idx;
  logic [bcc_pkg::CNT_W-1:0] ev_count;

  // pending event, held until we know whether it is the last one
  logic                       pend_valid;
  logic [bcc_pkg::KIND_W-1:0] pend_kind;
  logic [bcc_pkg::BTN_W-1:0]  pend_btn;

  // output register
  logic [bcc_pkg::KIND_W-1:0] out_kind;
  logic [bcc_pkg::BTN_W-1:0]  out_btn;

  logic [31:0]                req_idx_ext;
  logic [31:0]                scan_idx_ext;
  logic [IDX_W-1:0]           btn_addr;
  logic                       btn_in_range;
  logic [IDX_W-1:0]           addr;
  logic [bcc_pkg::MODE_W-1:0] cur_mode;
  logic [bcc_pkg::TIME_W-1:0] cur_elapsed;
  logic                       out_free;
  logic                       out_load;

  logic                       meets_min;
  logic [bcc_pkg::MODE_W-1:0] btn_mode_next;
  logic [bcc_pkg::TIME_W-1:0] btn_elapsed_next;
  logic                       btn_double;

  logic [bcc_pkg::TIME_W-1:0] tick_elapsed;
  logic                       hit_long;
  logic                       hit_click;
  logic                       scan_hit;
  logic [bcc_pkg::KIND_W-1:0] scan_kind;
  logic [bcc_pkg::BTN_W-1:0]  scan_btn;

  // address selection, one button per cycle
  assign req_idx_ext  = 32'(req_index);
  assign scan_idx_ext = 32'(scan_idx);
  assign btn_addr     = req_idx_ext[IDX_W-1:0];
  assign btn_in_range = (req_idx_ext < NUM_BUTTONS);
  assign addr         = cmd.scan_step ? scan_idx : btn_addr;
  assign cur_mode     = button_mode[addr];
  assign cur_elapsed  = elapsed_ms[addr];
  assign out_free     = !m_tvalid || m_tready;

  // button change: mode machine for the addressed button
  assign meets_min = (cur_elapsed >= min_press_ms);

  always_comb begin
    btn_mode_next    = cur_mode;
    btn_elapsed_next = cur_elapsed;
    btn_double       = 1'b0;
    unique case (cur_mode)
      bcc_pkg::MODE_PRESSED: begin
        if (!req_level) begin
          if (meets_min) begin
            btn_mode_next    = bcc_pkg::MODE_WAIT;
            btn_elapsed_next = '0;
          end else begin
            btn_mode_next = bcc_pkg::MODE_IDLE;
          end
        end
      end
      bcc_pkg::MODE_WAIT: begin
        if (!req_level) begin
          if (meets_min) begin
            btn_double       = 1'b1;
            btn_elapsed_next = '0;
          end
          btn_mode_next = bcc_pkg::MODE_IDLE;
        end else begin
          btn_elapsed_next = '0;
        end
      end
      default: begin
        if (req_level) begin
          btn_elapsed_next = '0;
          btn_mode_next    = bcc_pkg::MODE_PRESSED;
        end else begin
          btn_mode_next = bcc_pkg::MODE_IDLE;
        end
      end
    endcase
  end

  // tick scan: saturating count and timeout checks
  assign tick_elapsed = (cur_elapsed == {bcc_pkg::TIME_W{1'b1}}) ?
                        cur_elapsed : cur_elapsed + 1'b1;
  assign hit_long  = ((cur_mode == bcc_pkg::MODE_PRESSED) ||
                      (cur_mode == bcc_pkg::MODE_WAIT)) &&
                     (tick_elapsed >= long_click_ms);
  assign hit_click = (cur_mode == bcc_pkg::MODE_WAIT) &&
                     (tick_elapsed >= dblclick_window_ms);
  assign scan_hit  = (hit_long || hit_click) &&
                     (ev_count < bcc_pkg::CNT_W'(bcc_pkg::MAX_EVENTS));
  assign scan_kind = hit_long ? bcc_pkg::EV_LONG : bcc_pkg::EV_CLICK;
  assign scan_btn  = scan_idx_ext[bcc_pkg::BTN_W-1:0];

  // an event enters the output register this cycle
  assign out_load = (cmd.btn_step && btn_double && btn_in_range) ||
                    (cmd.scan_step && scan_hit && pend_valid) ||
                    cmd.flush;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      long_click_ms      <= bcc_pkg::LONG_CLICK_RST;
      min_press_ms       <= bcc_pkg::MIN_PRESS_RST;
      dblclick_window_ms <= bcc_pkg::DBL_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcc_pkg::REG_LONG_CLICK: long_click_ms      <= cfg_data;
        bcc_pkg::REG_MIN_PRESS:  min_press_ms       <= cfg_data;
        bcc_pkg::REG_DBL_WINDOW: dblclick_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-button state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        button_mode[i] <= bcc_pkg::MODE_IDLE;
        elapsed_ms[i]  <= '0;
      end
    end else if (cmd.btn_step && btn_in_range) begin
      button_mode[addr] <= btn_mode_next;
      elapsed_ms[addr]  <= btn_elapsed_next;
    end else if (cmd.scan_step) begin
      elapsed_ms[addr] <= tick_elapsed;
      if (scan_hit) begin
        button_mode[addr] <= bcc_pkg::MODE_IDLE;
      end
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_index <= s_tdata[1:0];
      req_level <= s_tdata[2];
    end
  end

  // scan counters, pending event and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      ev_count   <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.load) begin
        scan_idx <= '0;
        ev_count <= '0;
      end
      if (cmd.btn_step) begin
        pend_valid <= 1'b1;
        pend_btn   <= req_index;
        if (btn_double && btn_in_range) begin
          out_kind  <= bcc_pkg::EV_RELEASE;
          out_btn   <= req_index;
          m_tlast   <= 1'b0;
          pend_kind <= bcc_pkg::EV_DOUBLE;
        end else begin
          pend_kind <= req_level ? bcc_pkg::EV_PRESS : bcc_pkg::EV_RELEASE;
        end
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
        if (scan_hit) begin
          ev_count   <= ev_count + 1'b1;
          pend_valid <= 1'b1;
          pend_kind  <= scan_kind;
          pend_btn   <= scan_btn;
          if (pend_valid) begin
            out_kind <= pend_kind;
            out_btn  <= pend_btn;
            m_tlast  <= 1'b0;
          end
        end
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
        out_kind   <= pend_kind;
        out_btn    <= pend_btn;
        m_tlast    <= 1'b1;
      end
    end
  end

  assign m_tdata = {{(8 - bcc_pkg::BTN_W){1'b0}}, out_btn};
  assign m_tuser = out_kind;

  // status to the controller
  assign stat.req_op     = s_tuser;
  assign stat.scan_last  = (scan_idx == LAST_IDX);
  assign stat.out_free   = out_free;
  assign stat.pend_valid = pend_valid;

endmodule

/* hdl/button_click_classifier.sv */
// Button click classifier. Each request on the slave stream is either a button
// level change (tuser 0) or a one-millisecond tick (tuser 1). A level change
// always yields a press or release event and may add a double click. A tick
// bumps every button's saturating counter and reports long clicks and
// single-click timeouts in button order, at most four per tick; the scan
// visits one button per cycle through a single shared compare unit while the
// output register is free. Events are held one deep so that tlast can mark
// the final event of a request, and work stalls while the output is occupied.
// A tick with no timeout produces no output. Only buttons 0 to 3 can be
// addressed by a level change; event_button carries the low two bits of the
// button index. The user must write thresholds through the cfg port only
// while no request is in flight; the block itself does not enforce it.
module button_click_classifier #(
  parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // threshold registers: 0 long click, 1 minimum press, 2 double-click window
  input  logic                          cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // button_index[1:0], button_level[2], zero
  input  logic                          s_tuser,  // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,  // event_button[1:0], zero
  output logic [bcc_pkg::KIND_W-1:0]    m_tuser,  // event_kind
  output logic                          m_tlast
);

  bcc_pkg::cmd_t  cmd;
  bcc_pkg::stat_t stat;

  // sequencer
  bcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // button state, thresholds and event output
  bcc_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* dv/click_checker.sv */
`timescale 1ns / 1ps

module click_checker #(
  parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // button_index[1:0], button_level[2], zero
  input  logic                          s_tuser,  // op
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [7:0]                    m_tdata,  // event_button[1:0], zero
  input  logic [bcc_pkg::KIND_W-1:0]    m_tuser,  // event_kind
  input  logic                          m_tlast,
  output int                            errors,
  output int                            pending,
  output int                            checked
);
  import bcc_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BTN_W-1:0]  btn;
    logic              last;
  } click_event_t;

  click_event_t due_events[$];

  // thresholds as the block should hold them
  logic [CFG_W-1:0]  long_ms;
  logic [CFG_W-1:0]  press_ms;
  logic [CFG_W-1:0]  window_ms;

  // per-button mode and saturating millisecond counter
  logic [MODE_W-1:0] mode [NUM_BUTTONS];
  logic [TIME_W-1:0] held [NUM_BUTTONS];

  // one event held back so that the final one of a request gets last
  click_event_t      staged;
  bit                staged_ok;
  int                batch_len;

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic stage_event(input logic [KIND_W-1:0] kind, input logic [BTN_W-1:0] btn);
    if (staged_ok) due_events.push_back(staged);
    staged.kind = kind;
    staged.btn = btn;
    staged.last = 1'b0;
    staged_ok = 1'b1;
    batch_len++;
  endtask

  // events caused by one request, state moved along
  task automatic classify_request(input logic op, input logic [BTN_W-1:0] idx,
                                  input logic lvl);
    staged_ok = 1'b0;
    batch_len = 0;
    if (op == OP_BUTTON) begin
      stage_event(lvl ? EV_PRESS : EV_RELEASE, idx);
      if (idx < NUM_BUTTONS) begin
        case (mode[idx])
          MODE_PRESSED: begin
            if (!lvl) begin
              if (held[idx] >= press_ms) begin
                mode[idx] = MODE_WAIT;
                held[idx] = '0;
              end else begin
                mode[idx] = MODE_IDLE;
              end
            end
          end
          MODE_WAIT: begin
            if (!lvl) begin
              if (held[idx] >= press_ms) begin
                stage_event(EV_DOUBLE, idx);
                held[idx] = '0;
              end
              mode[idx] = MODE_IDLE;
            end else begin
              held[idx] = '0;
            end
          end
          // idle and the unused code behave alike
          default: begin
            if (lvl) begin
              held[idx] = '0;
              mode[idx] = MODE_PRESSED;
            end else begin
              mode[idx] = MODE_IDLE;
            end
          end
        endcase
      end
    end else begin
      // advance every counter, then scan in button order
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (held[i] != '1) held[i] = held[i] + 1'b1;
      end
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (batch_len < MAX_EVENTS) begin
          if ((mode[i] == MODE_PRESSED || mode[i] == MODE_WAIT) && held[i] >= long_ms) begin
            mode[i] = MODE_IDLE;
            stage_event(EV_LONG, BTN_W'(i));
          end else if (mode[i] == MODE_WAIT && held[i] >= window_ms) begin
            mode[i] = MODE_IDLE;
            stage_event(EV_CLICK, BTN_W'(i));
          end
        end
      end
    end
    if (staged_ok) begin
      staged.last = 1'b1;
      due_events.push_back(staged);
    end
  endtask

  // follow config writes, requests and events
  always @(posedge clk) begin
    click_event_t want;
    if (rst) begin
      long_ms = LONG_CLICK_RST;
      press_ms = MIN_PRESS_RST;
      window_ms = DBL_WINDOW_RST;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        mode[i] = MODE_IDLE;
        held[i] = '0;
      end
      due_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG_CLICK: long_ms = cfg_data;
          REG_MIN_PRESS:  press_ms = cfg_data;
          REG_DBL_WINDOW: window_ms = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) classify_request(s_tuser, s_tdata[BTN_W-1:0], s_tdata[BTN_W]);
      if (m_tvalid && m_tready) begin
        if (due_events.size() == 0) begin
          report($sformatf("event kind %0d button %0d with nothing expected",
                           m_tuser, m_tdata[BTN_W-1:0]));
        end else begin
          want = due_events.pop_front();
          checked++;
          if (m_tuser !== want.kind)
            report($sformatf("event_kind got %0d expected %0d", m_tuser, want.kind));
          if (m_tdata[BTN_W-1:0] !== want.btn)
            report($sformatf("event_button got %0d expected %0d",
                             m_tdata[BTN_W-1:0], want.btn));
          if (m_tlast !== want.last)
            report($sformatf("last got %0d expected %0d", m_tlast, want.last));
        end
      end
    end
    pending = due_events.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import bcc_pkg::*;

  localparam int NB            = NUM_BUTTONS_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PHASES = 5;
  localparam int LIMIT_NS      = 3_000_000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [7:0]           m_tdata;
  logic [KIND_W-1:0]    m_tuser;
  logic                 m_tlast;

  int mismatches;
  int outstanding;
  int compared;

  bit level_held [NB];
  bit tx_steady;
  bit rx_steady;
  int items_sent;
  int ticks_sent;
  int settings_used;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  button_click_classifier #(.NUM_BUTTONS(NB)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  click_checker #(.NUM_BUTTONS(NB)) scoreboard (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .errors(mismatches), .pending(outstanding), .checked(compared)
  );

  // one request, after a random gap, held until accepted
  task automatic send(input logic op, input logic [BTN_W-1:0] idx, input logic lvl);
    int unsigned gap;
    if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {5'b0, lvl, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (op == OP_TICK) ticks_sent++;
    else level_held[idx] = lvl;
  endtask

  // drain everything, then let a silent tick finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_thresholds(input logic [CFG_W-1:0] long_ms,
                                    input logic [CFG_W-1:0] press_ms,
                                    input logic [CFG_W-1:0] window_ms);
    cfg_we <= 1'b1;
    cfg_index <= REG_LONG_CLICK;
    cfg_data <= long_ms;
    @(posedge clk);
    cfg_index <= REG_MIN_PRESS;
    cfg_data <= press_ms;
    @(posedge clk);
    cfg_index <= REG_DBL_WINDOW;
    cfg_data <= window_ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // event receiver with random stalls
  initial begin
    int unsigned hold;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) rx_steady = !rx_steady;
      hold = rx_steady ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int tick_pct;
    int phase_len;
    logic [BTN_W-1:0] b;
    logic lvl;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_LONG_CLICK;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= OP_BUTTON;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short press under the reset thresholds
    send(OP_BUTTON, 2'd0, 1'b1);
    send(OP_BUTTON, 2'd0, 1'b0);
    wait_idle();

    program_thresholds(16'd4, 16'd2, 16'd3);
    // all four held into a long click on the same tick
    for (int i = 0; i < NB; i++) send(OP_BUTTON, BTN_W'(i), 1'b1);
    repeat (4) send(OP_TICK, 2'd3, 1'b1);
    // repeated press, qualifying release, press and release again for a double
    send(OP_BUTTON, 2'd0, 1'b1);
    send(OP_BUTTON, 2'd0, 1'b1);
    repeat (2) send(OP_TICK, 2'd0, 1'b0);
    send(OP_BUTTON, 2'd0, 1'b0);
    send(OP_BUTTON, 2'd0, 1'b1);
    repeat (2) send(OP_TICK, 2'd1, 1'b0);
    send(OP_BUTTON, 2'd0, 1'b0);
    // too short a press, then a release while idle
    send(OP_BUTTON, 2'd1, 1'b1);
    send(OP_BUTTON, 2'd1, 1'b0);
    send(OP_BUTTON, 2'd1, 1'b0);
    // single click once the window runs out
    send(OP_BUTTON, 2'd2, 1'b1);
    repeat (2) send(OP_TICK, 2'd2, 1'b1);
    send(OP_BUTTON, 2'd2, 1'b0);
    repeat (3) send(OP_TICK, 2'd0, 1'b1);
    wait_idle();

    // random phases, mostly alternating levels per button
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: program_thresholds(16'd1, 16'd0, 16'd1);
        1: program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: program_thresholds(CFG_W'($urandom_range(3, 12)), CFG_W'($urandom_range(0, 4)),
                                    CFG_W'($urandom_range(2, 8)));
      endcase
      phase_len = (p == 0) ? 30 : (p == 1) ? 20 : 30;
      tick_pct = $urandom_range(30, 70);
      repeat (phase_len) begin
        b = $urandom_range(0, NB - 1);
        if ($urandom_range(0, 99) < tick_pct) begin
          send(OP_TICK, b, 1'($urandom_range(0, 1)));
        end else begin
          lvl = ($urandom_range(0, 99) < 85) ? !level_held[b] : level_held[b];
          send(OP_BUTTON, b, lvl);
        end
      end
      wait_idle();
    end

    $display("covered %0d requests, %0d of them ticks, under %0d threshold settings",
             items_sent, ticks_sent, settings_used);
    $display("%0d events compared against the predicted sequence", compared);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard limit on the run
  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d events outstanding", outstanding);
    $display("status: fail");
    $finish;
  end

endmodule
